### design/wbds_pkg.sv
// Shared constants and types of the warp block dispatch scheduler.
package wbds_pkg;

   localparam int WarpSlotsDefault  = 64;
   localparam int BlockSlotsDefault = 16;

   localparam logic [1:0] OP_ASSIGN = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] CSR_BLOCK_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_WARP_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_ISSUE_BATCH  = 2'd2;
   localparam logic [1:0] CSR_RETIRE_THRES = 2'd3;

   localparam logic [4:0]  BLOCK_LIMIT_RST  = 5'd16;
   localparam logic [6:0]  WARP_LIMIT_RST   = 7'd64;
   localparam logic [7:0]  ISSUE_BATCH_RST  = 8'd8;
   localparam logic [14:0] RETIRE_THRES_RST = 15'd1000;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

### design/warp_block_dispatch_scheduler_top.sv
// Warp block dispatch scheduler: admits blocks, issues warps round robin, frees done blocks.
// Tick reads the queue, the warp memory, then writes back; assign walks the slots until the
// block has its warps; remove sweeps all slots. Rejected assigns, empty ticks, unused ops
// answer from idle. One item at a time: the result strobe comes in the cycle after the
// last step, and busy is low again in that cycle. The receiver cannot stall the result.
// Synchronous reset empties the queue, frees all slots and restores the register defaults.
module warp_block_dispatch_scheduler_top
   import wbds_pkg::*;
#(
   parameter int WARP_SLOTS  = WarpSlotsDefault,
   parameter int BLOCK_SLOTS = BlockSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_warp_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic        rsp_issued,
   output logic [5:0]  rsp_warp_slot,
   output logic [3:0]  rsp_block_slot,
   output logic        rsp_warp_retired,
   output logic        rsp_block_finished,
   output logic [4:0]  rsp_removed_blocks,
   output logic [4:0]  rsp_resident_blocks,
   output logic [6:0]  rsp_resident_warps,
   output logic        rsp_busy_res,
   output logic [31:0] rsp_idle_cycles
);

   localparam int WW    = (WARP_SLOTS > 1) ? $clog2(WARP_SLOTS) : 1;
   localparam int BW    = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
   localparam int WCW   = $clog2(WARP_SLOTS + 1);
   localparam int BCW   = $clog2(BLOCK_SLOTS + 1);
   localparam int SWEEP = (WARP_SLOTS >= BLOCK_SLOTS) ? WARP_SLOTS : BLOCK_SLOTS;
   localparam int SW    = $clog2(SWEEP + 1);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_ASSIGN    = 3'd1;
   localparam logic [2:0] ST_TICK_FIFO = 3'd2;
   localparam logic [2:0] ST_TICK_MEM  = 3'd3;
   localparam logic [2:0] ST_REMOVE    = 3'd4;

   logic [4:0]  blk_limit_ff;
   logic [6:0]  warp_limit_ff;
   logic [7:0]  batch_ff;
   logic [14:0] thres_ff;

   logic [2:0]  state_ff, state_in;
   logic [6:0]  n_ff;
   logic [6:0]  got_ff;
   logic        first_ff;
   logic [SW-1:0] walk_ff;
   logic [BW-1:0] bsel_ff;
   logic [WW-1:0] wsel_ff;
   logic [BLOCK_SLOTS-1:0] kill_ff;
   logic [BCW-1:0] removed_ff;

   logic [WARP_SLOTS-1:0]  warp_valid_ff;
   logic [BLOCK_SLOTS-1:0] blk_valid_ff, blk_done_ff;
   logic [6:0] blk_size_ff [BLOCK_SLOTS];
   logic [6:0] blk_ret_ff  [BLOCK_SLOTS];
   logic [BCW-1:0] blocks_ff;
   logic [WCW-1:0] total_ff;
   logic        running_ff;
   logic [31:0] idle_ff;

   logic        rv_ff, racc_ff, riss_ff, rret_ff, rfin_ff;
   logic [WW-1:0]  rws_ff;
   logic [BW-1:0]  rbs_ff;
   logic [BCW-1:0] rrem_ff;

   fifo_ctl_type   fctl;
   logic [WW-1:0]  fpush_data, fpop_data;
   logic [WCW-1:0] fcount;

   logic           mwe;
   logic [WW-1:0]  mwaddr, mraddr;
   logic [BW-1:0]  mwowner, mrowner;
   logic [15:0]    mwcount, mrcount;

   logic [7:0]     sum_in;
   logic           admit;
   logic [BW-1:0]  free_blk;
   logic [WW-1:0]  walk_w, prev_w;
   logic           take;
   logic [16:0]    csum;
   logic [6:0]     ret_in;

   wbds_fifo #(.DEPTH(WARP_SLOTS)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fctl),
      .push_data (fpush_data),
      .pop_data  (fpop_data),
      .count     (fcount)
   );

   wbds_warp_mem #(.WARP_SLOTS(WARP_SLOTS), .OWNER_W(BW)) u_wmem (
      .clock    (clock),
      .wr_en    (mwe),
      .wr_addr  (mwaddr),
      .wr_owner (mwowner),
      .wr_count (mwcount),
      .rd_addr  (mraddr),
      .rd_owner (mrowner),
      .rd_count (mrcount)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      free_blk = '0;
      for (int i = BLOCK_SLOTS - 1; i >= 0; i--) begin
         if (!blk_valid_ff[i]) begin
            free_blk = BW'(i);
         end
      end
   end

   assign sum_in = 8'(total_ff) + {1'b0, req_warp_count};
   assign admit  = (req_warp_count != 7'd0) && (5'(blocks_ff) < blk_limit_ff) &&
                   (blocks_ff < BCW'(BLOCK_SLOTS)) && (sum_in <= {1'b0, warp_limit_ff}) &&
                   (sum_in <= 8'(WARP_SLOTS));

   assign walk_w = walk_ff[WW-1:0];
   assign prev_w = WW'(walk_ff - 1'b1);
   assign take   = !warp_valid_ff[walk_w];
   assign csum   = {1'b0, mrcount} + {9'd0, batch_ff};
   assign ret_in = blk_ret_ff[mrowner] + 7'd1;

   always_comb begin
      fctl       = '0;
      fpush_data = wsel_ff;
      mwe        = 1'b0;
      mwaddr     = wsel_ff;
      mwowner    = mrowner;
      mwcount    = csum[15:0];
      mraddr     = walk_w;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_ASSIGN: if (admit) state_in = ST_ASSIGN;
                  OP_TICK: begin
                     if (fcount != '0) begin
                        fctl.pop = 1'b1;
                        state_in = ST_TICK_FIFO;
                     end
                  end
                  OP_REMOVE: state_in = ST_REMOVE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ASSIGN: begin
            if (take) begin
               fctl.push  = 1'b1;
               fpush_data = walk_w;
               mwe        = 1'b1;
               mwaddr     = walk_w;
               mwowner    = bsel_ff;
               mwcount    = '0;
               if (got_ff + 7'd1 == n_ff) state_in = ST_IDLE;
            end
         end
         ST_TICK_FIFO: begin
            mraddr   = fpop_data;
            state_in = ST_TICK_MEM;
         end
         ST_TICK_MEM: begin
            mwe = 1'b1;
            if (csum < {2'b0, thres_ff}) fctl.push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_REMOVE: begin
            if (walk_ff == SW'(SWEEP)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_limit_ff  <= BLOCK_LIMIT_RST;
         warp_limit_ff <= WARP_LIMIT_RST;
         batch_ff      <= ISSUE_BATCH_RST;
         thres_ff      <= RETIRE_THRES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLOCK_LIMIT:  blk_limit_ff  <= csr_wdata[4:0];
            CSR_WARP_LIMIT:   warp_limit_ff <= csr_wdata[6:0];
            CSR_ISSUE_BATCH:  batch_ff      <= csr_wdata[7:0];
            CSR_RETIRE_THRES: thres_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         warp_valid_ff <= '0;
         blk_valid_ff  <= '0;
         blk_done_ff   <= '0;
         blocks_ff     <= '0;
         total_ff      <= '0;
         running_ff    <= 1'b0;
         idle_ff       <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  racc_ff <= 1'b0;
                  riss_ff <= 1'b0;
                  rret_ff <= 1'b0;
                  rfin_ff <= 1'b0;
                  rws_ff  <= '0;
                  rbs_ff  <= '0;
                  rrem_ff <= '0;
                  n_ff    <= req_warp_count;
                  got_ff  <= '0;
                  first_ff <= 1'b1;
                  walk_ff <= '0;
                  case (req_op)
                     OP_ASSIGN: begin
                        if (admit) begin
                           bsel_ff <= free_blk;
                           blk_valid_ff[free_blk] <= 1'b1;
                           blk_done_ff[free_blk]  <= 1'b0;
                           blk_size_ff[free_blk]  <= req_warp_count;
                           blk_ret_ff[free_blk]   <= '0;
                        end else begin
                           rv_ff <= 1'b1;
                        end
                     end
                     OP_TICK: begin
                        if (fcount == '0) begin
                           idle_ff <= idle_ff + 32'd1;
                           rv_ff   <= 1'b1;
                        end
                     end
                     OP_REMOVE: begin
                        kill_ff    <= blk_valid_ff & blk_done_ff;
                        removed_ff <= '0;
                     end
                     default: rv_ff <= 1'b1;
                  endcase
               end
            end
            ST_ASSIGN: begin
               walk_ff <= walk_ff + 1'b1;
               if (take) begin
                  warp_valid_ff[walk_w] <= 1'b1;
                  got_ff   <= got_ff + 7'd1;
                  first_ff <= 1'b0;
                  if (first_ff) rws_ff <= walk_w;
                  if (got_ff + 7'd1 == n_ff) begin
                     total_ff   <= total_ff + WCW'(n_ff);
                     blocks_ff  <= blocks_ff + 1'b1;
                     running_ff <= 1'b1;
                     racc_ff    <= 1'b1;
                     rbs_ff     <= bsel_ff;
                     rv_ff      <= 1'b1;
                  end
               end
            end
            ST_TICK_FIFO: begin
               wsel_ff <= fpop_data;
            end
            ST_TICK_MEM: begin
               riss_ff <= 1'b1;
               rws_ff  <= wsel_ff;
               rbs_ff  <= mrowner;
               rv_ff   <= 1'b1;
               if (csum >= {2'b0, thres_ff}) begin
                  rret_ff <= 1'b1;
                  blk_ret_ff[mrowner] <= ret_in;
                  if (ret_in >= blk_size_ff[mrowner]) begin
                     blk_done_ff[mrowner] <= 1'b1;
                     rfin_ff <= 1'b1;
                  end
               end
            end
            ST_REMOVE: begin
               walk_ff <= walk_ff + 1'b1;
               // Owner data is registered and belongs to the previous read address.
               if (walk_ff != '0 && walk_ff <= SW'(WARP_SLOTS)) begin
                  if (warp_valid_ff[prev_w] && kill_ff[mrowner]) begin
                     warp_valid_ff[prev_w] <= 1'b0;
                  end
               end
               if (walk_ff < SW'(BLOCK_SLOTS)) begin
                  if (kill_ff[walk_ff[BW-1:0]]) begin
                     total_ff   <= total_ff - WCW'(blk_size_ff[walk_ff[BW-1:0]]);
                     removed_ff <= removed_ff + 1'b1;
                  end
               end
               if (walk_ff == SW'(SWEEP)) begin
                  blk_valid_ff <= blk_valid_ff & ~kill_ff;
                  blk_done_ff  <= blk_done_ff & ~kill_ff;
                  blocks_ff    <= blocks_ff - removed_ff;
                  if (blocks_ff == removed_ff) running_ff <= 1'b0;
                  rrem_ff <= removed_ff;
                  rv_ff   <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_accepted        = racc_ff;
   assign rsp_issued          = riss_ff;
   assign rsp_warp_slot       = 6'(rws_ff);
   assign rsp_block_slot      = 4'(rbs_ff);
   assign rsp_warp_retired    = rret_ff;
   assign rsp_block_finished  = rfin_ff;
   assign rsp_removed_blocks  = 5'(rrem_ff);
   assign rsp_resident_blocks = 5'(blocks_ff);
   assign rsp_resident_warps  = 7'(total_ff);
   assign rsp_busy_res        = running_ff;
   assign rsp_idle_cycles     = idle_ff;

endmodule

### design/wbds_fifo.sv
// Ready queue of warp slots held in a synchronous memory with head and tail pointers.
module wbds_fifo
   import wbds_pkg::*;
#(
   parameter int DEPTH = WarpSlotsDefault,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  fifo_ctl_type  ctl,
   input  logic [AW-1:0] push_data,
   output logic [AW-1:0] pop_data,
   output logic [CW-1:0] count
);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] head_ff, tail_ff, rd_ff;
   logic [CW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (ctl.push) begin
            tail_ff <= (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (ctl.pop) begin
            head_ff <= (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         if (ctl.push && !ctl.pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (ctl.pop && !ctl.push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      if (ctl.pop) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign pop_data = rd_ff;
   assign count    = count_ff;

endmodule

### design/wbds_warp_mem.sv
// Per-warp owner and instruction count memories with one write and one read port.
module wbds_warp_mem
   import wbds_pkg::*;
#(
   parameter int WARP_SLOTS = WarpSlotsDefault,
   parameter int OWNER_W    = 4,
   localparam int AW = (WARP_SLOTS > 1) ? $clog2(WARP_SLOTS) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [OWNER_W-1:0] wr_owner,
   input  logic [15:0]        wr_count,
   input  logic [AW-1:0]      rd_addr,
   output logic [OWNER_W-1:0] rd_owner,
   output logic [15:0]        rd_count
);

   logic [OWNER_W-1:0] owner_mem [WARP_SLOTS];
   logic [15:0]        count_mem [WARP_SLOTS];
   logic [OWNER_W-1:0] owner_ff;
   logic [15:0]        count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_owner;
         count_mem[wr_addr] <= wr_count;
      end
      owner_ff <= owner_mem[rd_addr];
      count_ff <= count_mem[rd_addr];
   end

   assign rd_owner = owner_ff;
   assign rd_count = count_ff;

endmodule

### design/wbds_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
module wbds_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_accepted,
   input logic       rsp_issued,
   input logic       rsp_warp_retired,
   input logic       rsp_block_finished,
   input logic [4:0] rsp_resident_blocks
);

   // Every accepted item either finishes at once or keeps the block busy.
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither answered nor in progress");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_issued))
      else $error("result both admitted a block and issued a warp");

   a_retire_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_finished) |-> (rsp_warp_retired && rsp_issued))
      else $error("block finished without a retiring issue");

   a_block_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_resident_blocks <= 5'd16))
      else $error("resident block count out of range");

endmodule

bind warp_block_dispatch_scheduler_top wbds_checker u_wbds_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_accepted        (rsp_accepted),
   .rsp_issued          (rsp_issued),
   .rsp_warp_retired    (rsp_warp_retired),
   .rsp_block_finished  (rsp_block_finished),
   .rsp_resident_blocks (rsp_resident_blocks)
);
